// ----- src/bsf_pkg.sv -----
package bsf_pkg;

  localparam int BufferBytes = 1024;
  localparam int AddrW = $clog2(BufferBytes);
  localparam int LenW = 10;
  localparam int ByteW = 8;
  localparam int FuncW = 2;
  localparam int StatW = 3;
  localparam int CmpW = ((AddrW > LenW) ? AddrW : LenW) + 1;

  typedef enum logic [FuncW-1:0] {
    FN_RESERVE = 2'd0,
    FN_PUT     = 2'd1,
    FN_GET     = 2'd2,
    FN_NONE    = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_WLOCK   = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_NORSV   = 3'd3,
    ST_LONG    = 3'd4,
    ST_EMPTY   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } fsm_e;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] byte_out;
    logic             end_of_string;
    logic [LenW-1:0]  string_length;
  } res_t;

endpackage

// ----- src/bsf_in_if.sv -----
interface bsf_in_if import bsf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [LenW-1:0]  reserve_length;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output func, output reserve_length, output byte_in,
                  input ready);
  modport sink (input valid, input func, input reserve_length, input byte_in,
                output ready);
endinterface

// ----- src/bsf_out_if.sv -----
interface bsf_out_if import bsf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [ByteW-1:0] byte_out;
  logic             end_of_string;
  logic [LenW-1:0]  string_length;

  modport source (output valid, output status, output byte_out, output end_of_string,
                  output string_length, input ready);
  modport sink (input valid, input status, input byte_out, input end_of_string,
                input string_length, output ready);
endinterface

// ----- src/bsf_cfg_if.sv -----
interface bsf_cfg_if;
  logic valid;
  logic ready;
  logic keep_long;

  modport source (output valid, output keep_long, input ready);
  modport sink (input valid, input keep_long, output ready);
endinterface

// ----- src/bsf_store.sv -----
module bsf_store import bsf_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [ByteW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem_q [BufferBytes];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bsf_res_q.sv -----
module bsf_res_q import bsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  bsf_out_if.source out_ch
);

  res_t       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  assign full_o               = (cnt_q == 2'd2);
  assign out_ch.valid         = (cnt_q != 2'd0);
  assign out_ch.status        = ent_q[rd_q].status;
  assign out_ch.byte_out      = ent_q[rd_q].byte_out;
  assign out_ch.end_of_string = ent_q[rd_q].end_of_string;
  assign out_ch.string_length = ent_q[rd_q].string_length;

endmodule

// ----- src/bipartite_string_fifo.sv -----
// FIFO of zero-terminated byte strings in a two-region byte store. Reserve an item for
// length+1 bytes, stream the bytes in with put items (a zero commits), and pull them out
// with get items, one result per item. Reserve, put and an empty get push from S_IDLE;
// a get that reads a byte pushes from S_READ, after the store's registered read. Results
// wait in a two-entry output queue, so input is taken while results are pending until it
// is full. keep_long is written over its own channel, by the user only while idle; not enforced.
module bipartite_string_fifo import bsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bsf_in_if.sink    in_ch,
  bsf_out_if.source out_ch,
  bsf_cfg_if.sink   cfg_ch
);

  fsm_e             state_q, state_d;
  logic [AddrW-1:0] a_rd_q, a_rd_d, a_wr_q, a_wr_d;
  logic [AddrW-1:0] b_rd_q, b_rd_d, b_wr_q, b_wr_d;
  logic             mode_w_q, mode_w_d, mode_r_q, mode_r_d;
  logic             rsv_active_q, rsv_active_d;
  logic [AddrW-1:0] rsv_next_q, rsv_next_d, rsv_limit_q, rsv_limit_d;
  logic [LenW-1:0]  rd_cnt_q, rd_cnt_d;
  logic             keep_long_q;

  logic             accept;
  logic             push;
  res_t             res;
  logic             q_full;

  logic             st_we, st_re;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [ByteW-1:0] st_wdata, st_rdata;

  logic [AddrW-1:0] cur_wp, rd_rp, rd_wp, rp_new;
  logic [AddrW-1:0] hi_w, lo_w, hi_r, at_start, at_end, avail, new_wp;
  logic [AddrW-1:0] put_count, next_inc;
  logic             same, swap, new_w, fits;
  logic [CmpW-1:0]  need;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_q == S_IDLE) && !q_full;
  assign cfg_ch.ready = 1'b1;

  // space bookkeeping
  assign cur_wp   = mode_w_q ? b_wr_q : a_wr_q;
  assign rd_rp    = mode_r_q ? b_rd_q : a_rd_q;
  assign rd_wp    = mode_r_q ? b_wr_q : a_wr_q;
  assign rp_new   = rd_rp + AddrW'(1);
  assign hi_w     = (a_wr_q > b_wr_q) ? a_wr_q : b_wr_q;
  assign lo_w     = (a_wr_q < b_wr_q) ? a_wr_q : b_wr_q;
  assign hi_r     = (a_rd_q > b_rd_q) ? a_rd_q : b_rd_q;
  assign at_start = (hi_r > lo_w) ? (hi_r - lo_w) : '0;
  assign at_end   = AddrW'(BufferBytes - 1) - hi_w;
  assign same     = (mode_w_q == mode_r_q);
  assign swap     = same && (at_end < at_start);
  assign avail    = (same && !swap) ? at_end : at_start;
  assign new_w    = mode_w_q ^ swap;
  assign new_wp   = new_w ? b_wr_q : a_wr_q;
  assign need     = CmpW'(in_ch.reserve_length) + CmpW'(1);
  assign fits     = (CmpW'(avail) >= need);

  assign put_count = (rsv_next_q > cur_wp) ? (rsv_next_q - cur_wp) : '0;
  assign next_inc  = rsv_next_q + AddrW'(1);

  always_comb begin
    state_d      = state_q;
    a_rd_d       = a_rd_q;
    a_wr_d       = a_wr_q;
    b_rd_d       = b_rd_q;
    b_wr_d       = b_wr_q;
    mode_w_d     = mode_w_q;
    mode_r_d     = mode_r_q;
    rsv_active_d = rsv_active_q;
    rsv_next_d   = rsv_next_q;
    rsv_limit_d  = rsv_limit_q;
    rd_cnt_d     = rd_cnt_q;
    push         = 1'b0;
    res          = '0;
    res.status   = ST_OK;
    st_we        = 1'b0;
    st_waddr     = rsv_next_q;
    st_wdata     = '0;
    st_re        = 1'b0;
    st_raddr     = rd_rp;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_e'(in_ch.func))
            FN_RESERVE: begin
              push = 1'b1;
              if (rsv_active_q) begin
                res.status = ST_WLOCK;
              end else begin
                mode_w_d = new_w;
                if (!fits) begin
                  res.status = ST_NOSPACE;
                end else begin
                  rsv_next_d   = new_wp;
                  rsv_limit_d  = new_wp + AddrW'(in_ch.reserve_length) + AddrW'(1);
                  rsv_active_d = 1'b1;
                end
              end
            end
            FN_PUT: begin
              push = 1'b1;
              if (!rsv_active_q) begin
                res.status = ST_NORSV;
              end else begin
                st_we = 1'b1;
                if (in_ch.byte_in == '0) begin
                  if (put_count != '0) begin
                    if (mode_w_q) begin
                      b_wr_d = next_inc;
                    end else begin
                      a_wr_d = next_inc;
                    end
                    res.end_of_string = 1'b1;
                    res.string_length = LenW'(put_count);
                  end
                  rsv_active_d = 1'b0;
                end else if (next_inc < rsv_limit_q) begin
                  st_wdata   = in_ch.byte_in;
                  rsv_next_d = next_inc;
                end else begin
                  res.status = ST_LONG;
                  if (keep_long_q) begin
                    if (mode_w_q) begin
                      b_wr_d = rsv_limit_q;
                    end else begin
                      a_wr_d = rsv_limit_q;
                    end
                    res.end_of_string = 1'b1;
                    res.string_length = LenW'(put_count);
                  end
                  rsv_active_d = 1'b0;
                end
              end
            end
            FN_GET: begin
              if (rd_rp >= rd_wp) begin
                push       = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                st_re   = 1'b1;
                state_d = S_READ;
              end
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        push         = 1'b1;
        state_d      = S_IDLE;
        res.byte_out = st_rdata;
        if (mode_r_q) begin
          b_rd_d = rp_new;
        end else begin
          a_rd_d = rp_new;
        end
        if (st_rdata != '0) begin
          if (rd_cnt_q != '1) begin
            rd_cnt_d = rd_cnt_q + LenW'(1);
          end
        end else begin
          res.end_of_string = 1'b1;
          res.string_length = rd_cnt_q;
          rd_cnt_d          = '0;
          // drained region gets recycled
          if ((rp_new >= rd_wp) && ((mode_r_q != mode_w_q) || !rsv_active_q)) begin
            if (mode_r_q) begin
              b_rd_d = '0;
              b_wr_d = '0;
            end else begin
              a_rd_d = '0;
              a_wr_d = '0;
            end
            mode_r_d = ~mode_r_q;
            if (mode_r_q == mode_w_q) begin
              mode_w_d = ~mode_w_q;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      a_rd_q       <= '0;
      a_wr_q       <= '0;
      b_rd_q       <= '0;
      b_wr_q       <= '0;
      mode_w_q     <= 1'b0;
      mode_r_q     <= 1'b0;
      rsv_active_q <= 1'b0;
      rsv_next_q   <= '0;
      rsv_limit_q  <= '0;
      rd_cnt_q     <= '0;
      keep_long_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      a_rd_q       <= a_rd_d;
      a_wr_q       <= a_wr_d;
      b_rd_q       <= b_rd_d;
      b_wr_q       <= b_wr_d;
      mode_w_q     <= mode_w_d;
      mode_r_q     <= mode_r_d;
      rsv_active_q <= rsv_active_d;
      rsv_next_q   <= rsv_next_d;
      rsv_limit_q  <= rsv_limit_d;
      rd_cnt_q     <= rd_cnt_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        keep_long_q <= cfg_ch.keep_long;
      end
    end
  end

  bsf_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  bsf_res_q u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .full_o (q_full),
    .out_ch (out_ch)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_IDLE)
    else $error("read cycle did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsv_active_q |-> rsv_next_q < rsv_limit_q)
    else $error("reservation cursor past its limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_rd_q <= a_wr_q) && (b_rd_q <= b_wr_q))
    else $error("read pointer ahead of write pointer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("result pushed into full queue");

endmodule
